FILE: rtl/two_stack_sorter_top_defines.svh
// ----------------------------------------------------------------------------
// Two-stack sorter assertion macros
// Property wrappers shared by the sorter's assertion checks.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_SORTER_TOP_DEFINES_SVH
`define TWO_STACK_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define TSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// Two-stack sorter package
// Record layout, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int SCORE_W         = 7;
  localparam int TAG_W           = 16;
  localparam int STACK_DEPTH_DEF = 64;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_POP,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic load;       // take an input beat
    logic pop;        // pop input stack, read both tops
    logic move;       // sorted top back onto input stack
    logic push;       // held record onto sorted stack
    logic emit_rd;    // pop sorted stack for output
    logic emit_ld;    // load output register
    logic end_batch;  // clear sticky overflow
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic srt_empty;
    logic greater;
    logic out_taken;
  } status_t;

endpackage

FILE: rtl/tss_ctrl.sv
// ----------------------------------------------------------------------------
// Two-stack sorter controller
// Sequences loading, the two-stack sort and the output run.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  tss_pkg::status_t  status,
  output tss_pkg::cmd_t     cmd,
  output logic              in_stall
);
  import tss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid && in_last) state_nxt = S_POP;
      end
      S_POP: begin
        state_nxt = status.in_empty ? S_EMIT_RD : S_CMP;
      end
      S_CMP: begin
        if (!status.greater) state_nxt = S_POP;
      end
      S_EMIT_RD: begin
        state_nxt = status.srt_empty ? S_LOAD : S_EMIT_LD;
      end
      S_EMIT_LD: begin
        state_nxt = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (status.out_taken) state_nxt = status.srt_empty ? S_LOAD : S_EMIT_LD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_POP: begin
        cmd.pop = !status.in_empty;
      end
      S_CMP: begin
        cmd.move = status.greater;
        cmd.push = !status.greater;
      end
      S_EMIT_RD: begin
        cmd.emit_rd   = !status.srt_empty;
        cmd.end_batch = status.srt_empty;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
      end
      S_EMIT_WAIT: begin
        // fetch the next entry as soon as the current beat leaves
        cmd.emit_rd   = status.out_taken && !status.srt_empty;
        cmd.end_batch = status.out_taken && status.srt_empty;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/tss_dpath.sv
// ----------------------------------------------------------------------------
// Two-stack sorter datapath
// Both stack memories, their top counters, overflow flag and output register.
// ----------------------------------------------------------------------------
module tss_dpath #(
  parameter int STACK_DEPTH = tss_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tss_pkg::cmd_t                cmd,
  output tss_pkg::status_t             status,
  input  logic [tss_pkg::SCORE_W-1:0]  in_score,
  input  logic [tss_pkg::TAG_W-1:0]    in_tag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tss_pkg::SCORE_W-1:0]  out_score,
  output logic [tss_pkg::TAG_W-1:0]    out_tag,
  output logic                         out_last,
  output logic                         out_overflow
);
  import tss_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  rec_t in_mem  [STACK_DEPTH];
  rec_t srt_mem [STACK_DEPTH];

  logic [CW-1:0] in_top_r, in_top_nxt;
  logic [CW-1:0] srt_top_r, srt_top_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;

  rec_t          in_rd_r, srt_rd_r;
  rec_t          out_rec_r;
  logic          out_last_r, out_ovf_r;

  logic [CW-1:0] in_dec1, srt_dec1, srt_dec2;
  logic          in_full;
  logic          in_wr_en, srt_wr_en, in_rd_en, srt_rd_en;
  logic [IW-1:0] in_wr_addr, in_rd_addr, srt_wr_addr, srt_rd_addr;
  rec_t          in_wr_data;
  logic          taken;

  assign in_dec1  = in_top_r - CW'(1);
  assign srt_dec1 = srt_top_r - CW'(1);
  assign srt_dec2 = srt_top_r - CW'(2);
  assign in_full  = (in_top_r == CW'(STACK_DEPTH));
  assign taken    = out_valid_r && !out_stall;

  // input stack: loaded beats and entries moved back from the sorted stack
  assign in_wr_en   = (cmd.load && !in_full) || cmd.move;
  assign in_wr_addr = in_top_r[IW-1:0];
  assign in_wr_data = cmd.move ? srt_rd_r : rec_t'{score: in_score, tag: in_tag};
  assign in_rd_en   = cmd.pop;
  assign in_rd_addr = in_dec1[IW-1:0];

  // sorted stack: after a move the next top sits two below the old count
  assign srt_wr_en   = cmd.push;
  assign srt_wr_addr = srt_top_r[IW-1:0];
  assign srt_rd_en   = cmd.pop || cmd.move || cmd.emit_rd;
  assign srt_rd_addr = cmd.move ? srt_dec2[IW-1:0] : srt_dec1[IW-1:0];

  always_ff @(posedge clk) begin
    if (in_wr_en) in_mem[in_wr_addr] <= in_wr_data;
    if (in_rd_en) in_rd_r <= in_mem[in_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (srt_wr_en) srt_mem[srt_wr_addr] <= in_rd_r;
    if (srt_rd_en) srt_rd_r <= srt_mem[srt_rd_addr];
  end

  always_comb begin
    in_top_nxt    = in_top_r;
    srt_top_nxt   = srt_top_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if ((cmd.load && !in_full) || cmd.move) in_top_nxt = in_top_r + CW'(1);
    if (cmd.pop) in_top_nxt = in_dec1;
    if (cmd.move || cmd.emit_rd) srt_top_nxt = srt_dec1;
    if (cmd.push) srt_top_nxt = srt_top_r + CW'(1);
    if (cmd.load && in_full) ovf_nxt = 1'b1;
    if (cmd.end_batch) ovf_nxt = 1'b0;
    if (cmd.emit_ld) begin
      out_valid_nxt = 1'b1;
    end else if (taken) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_top_r    <= '0;
      srt_top_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_top_r    <= in_top_nxt;
      srt_top_r   <= srt_top_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_rec_r  <= srt_rd_r;
      out_last_r <= (srt_top_r == '0);
      out_ovf_r  <= ovf_r;
    end
  end

  assign status.in_empty  = (in_top_r == '0);
  assign status.srt_empty = (srt_top_r == '0);
  assign status.greater   = (srt_top_r != '0) && (srt_rd_r.score > in_rd_r.score);
  assign status.out_taken = taken;

  assign out_valid    = out_valid_r;
  assign out_score    = out_rec_r.score;
  assign out_tag      = out_rec_r.tag;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

FILE: rtl/two_stack_sorter_top.sv
// ----------------------------------------------------------------------------
// Two-stack sorter
// Collects a batch of scored records and emits it in descending score order.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_stall    in_score[6:0], in_tag[15:0], in_last
// out      out_valid/out_stall  out_score[6:0], out_tag[15:0], out_last, out_overflow
//
// Loading accepts one beat per cycle; beats beyond STACK_DEPTH are dropped and flag
// out_overflow for the batch. After the last beat the sort pops each input record,
// moves sorted entries of greater score back onto the input stack and pushes the
// record, O(n^2) overall, set by the single read port of each stack memory. Each
// output beat is read from the sorted stack, then loaded into the output register;
// the next is read once the current beat leaves. in_stall stays high from the last
// beat until the final output beat leaves. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "two_stack_sorter_top_defines.svh"

module two_stack_sorter_top #(
  parameter int STACK_DEPTH = tss_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tss_pkg::SCORE_W-1:0]  in_score,
  input  logic [tss_pkg::TAG_W-1:0]    in_tag,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tss_pkg::SCORE_W-1:0]  out_score,
  output logic [tss_pkg::TAG_W-1:0]    out_tag,
  output logic                         out_last,
  output logic                         out_overflow
);
  import tss_pkg::*;

  cmd_t    cmd;
  status_t status;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tss_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_score     (in_score),
    .in_tag       (in_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_score    (out_score),
    .out_tag      (out_tag),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  `TSS_ASSERT_NOW(a_no_out_while_loading, !in_stall, !out_valid, "output beat during loading")
  `TSS_ASSERT_NEXT(a_last_in_stalls, in_valid && !in_stall && in_last, in_stall, "sort skipped")
  `TSS_ASSERT_NEXT(a_last_out_reopens, out_valid && !out_stall && out_last, !in_stall, "no reopen")
  `TSS_ASSERT_NOW(a_move_nonempty, cmd.move, !status.srt_empty, "move from empty sorted stack")

endmodule

FILE: verif/tb_two_stack_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack sorter testbench
// Feeds batches of scored records, predicts each sorted output beat with an
// independent two-stack sort, and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_two_stack_sorter_top;
  import tss_pkg::*;

  localparam int DEPTH      = STACK_DEPTH_DEF;
  localparam int RAND_BEATS = 400;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } in_beat_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               last;
    logic               overflow;
  } sorted_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SCORE_W-1:0] in_score = '0;
  logic [TAG_W-1:0]   in_tag = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SCORE_W-1:0] out_score;
  logic [TAG_W-1:0]   out_tag;
  logic               out_last;
  logic               out_overflow;

  in_beat_t     pending_beats[$];
  in_beat_t     next_beat;
  rec_t         batch_stack[$];
  logic         batch_dropped = 1'b0;
  sorted_beat_t sorted_expect[$];
  sorted_beat_t want;
  int           beats_taken = 0;
  int           beats_seen = 0;
  int           errors = 0;

  always #6 clk = ~clk;

  two_stack_sorter_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_score     (in_score),
    .in_tag       (in_tag),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_score    (out_score),
    .out_tag      (out_tag),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  // Sort the held batch the two-stack way and queue the output beats
  function automatic void sort_batch();
    rec_t ordered[$];
    rec_t held;
    sorted_beat_t b;
    while (batch_stack.size() > 0) begin
      held = batch_stack.pop_back();
      while (ordered.size() > 0 && ordered[$].score > held.score)
        batch_stack.push_back(ordered.pop_back());
      ordered.push_back(held);
    end
    while (ordered.size() > 0) begin
      held = ordered.pop_back();
      b.score    = held.score;
      b.tag      = held.tag;
      b.last     = (ordered.size() == 0);
      b.overflow = batch_dropped;
      sorted_expect.push_back(b);
    end
    batch_dropped = 1'b0;
  endfunction

  function automatic void take_record(logic [SCORE_W-1:0] score, logic [TAG_W-1:0] tag,
                                      logic last);
    rec_t r;
    r.score = score;
    r.tag   = tag;
    if (batch_stack.size() < DEPTH) batch_stack.push_back(r);
    else batch_dropped = 1'b1;
    if (last) sort_batch();
  endfunction

  task automatic add_beat(int score, int tag, bit last);
    in_beat_t b;
    b.score = score[SCORE_W-1:0];
    b.tag   = tag[TAG_W-1:0];
    b.last  = last;
    pending_beats.push_back(b);
  endtask

  // Random batch; a small score pool now and then forces ties
  task automatic add_batch(int len);
    bit tied;
    int pool[3];
    tied = ($urandom_range(0, 99) < 30);
    foreach (pool[i]) pool[i] = $urandom_range(0, 127);
    for (int i = 0; i < len; i++)
      add_beat(tied ? pool[$urandom_range(0, 2)] : $urandom_range(0, 127),
               $urandom_range(0, 65535), i == len - 1);
  endtask

  // Input driver: present the next beat once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_record(in_score, in_tag, in_last);
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 &&
            !((beats_taken < 200 || beats_taken >= 300) && $urandom_range(0, 99) < 14)) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_score <= next_beat.score;
          in_tag   <= next_beat.tag;
          in_last  <= next_beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (sorted_expect.size() == 0) begin
          $error("output beat with nothing expected: score %0d tag %0h", out_score, out_tag);
          errors++;
        end else begin
          want = sorted_expect.pop_front();
          if (out_score !== want.score) begin
            $error("out_score: expected %0d, got %0d", want.score, out_score);
            errors++;
          end
          if (out_tag !== want.tag) begin
            $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $error("out_overflow: expected %0b, got %0b", want.overflow, out_overflow);
            errors++;
          end
        end
      end
      out_stall <= (beats_seen < 150 || beats_seen >= 300) && ($urandom_range(0, 99) < 14);
    end
  end

  initial begin
    int queued;
    int len;

    // Single records at the field extremes
    add_beat(0, 16'h0000, 1'b1);
    add_beat(127, 16'hFFFF, 1'b1);
    // Equal scores throughout
    for (int i = 0; i < 5; i++) add_beat(50, 16'h1000 + i, i == 4);
    // Ties mixed with the extremes of the score range
    add_beat(100, 16'h2001, 1'b0);
    add_beat(101, 16'h2002, 1'b0);
    add_beat(0, 16'h2003, 1'b0);
    add_beat(127, 16'h2004, 1'b0);
    add_beat(100, 16'h2005, 1'b0);
    add_beat(0, 16'h2006, 1'b1);
    // Already ascending, then already descending
    for (int i = 0; i < 4; i++) add_beat(10 * i, 16'h3000 + i, i == 3);
    for (int i = 0; i < 4; i++) add_beat(90 - 10 * i, 16'h4000 + i, i == 3);

    // Exactly full, then two beats past full so the last two beats are dropped
    add_batch(DEPTH);
    add_batch(DEPTH + 2);
    queued = 2 * DEPTH + 2;
    while (queued < RAND_BEATS) begin
      len = ($urandom_range(0, 99) < 8) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                        : $urandom_range(1, 12);
      add_batch(len);
      queued += len;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() > 0 || in_valid) @(posedge clk);
    while (sorted_expect.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb_two_stack_sorter_top OK");
    else $display("tb_two_stack_sorter_top NOT OK");
    $finish;
  end

  initial begin
    #6ms;
    $display("tb_two_stack_sorter_top NOT OK");
    $finish;
  end

endmodule
